// ----- hw/rtl/ttlc_pkg.sv -----
// shared types, codes and constants for the timetable link cost block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ttlc_pkg;

   // field widths
   localparam int TIME_BITS     = 20;
   localparam int FREE_W        = 24;
   localparam int PERIOD_W      = 17;
   localparam int LINK_COST_W   = 25;
   localparam int SEL_INDEX_W   = 4;
   localparam int STATUS_W      = 2;
   // internal signed cost width, holds arrival minus query plus one period
   // and the starting cost of 100 periods
   localparam int COST_W        = 26;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 24;

   localparam int MAX_MISSIONS_DEF = 16;

   // word kinds
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_CLEAR   = 2'd1;
   localparam logic [1:0] KIND_UNTIMED = 2'd2;
   localparam logic [1:0] KIND_TIMED   = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ORDER    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_LINK  = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FREE_COST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_FREE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD    = 2'd2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd86400;

   typedef struct packed {
      logic [1:0]           kind;
      logic [TIME_BITS-1:0] depart_at;
      logic [TIME_BITS-1:0] arrive_at;
      logic [TIME_BITS-1:0] query_time;
   } req_type;

   typedef struct packed {
      logic signed [LINK_COST_W-1:0] link_cost;
      logic                          selected_valid;
      logic [SEL_INDEX_W-1:0]        selected_index;
      logic [TIME_BITS-1:0]          chosen_departure;
      logic [TIME_BITS-1:0]          chosen_arrival;
      logic [STATUS_W-1:0]           status;
   } rsp_type;

   typedef struct packed {
      logic [FREE_W-1:0]   free_cost_value;
      logic                has_free_link;
      logic [PERIOD_W-1:0] period_length;
   } cfg_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] depart;
      logic [TIME_BITS-1:0] arrive;
   } mission_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SETUP,
      ENG_SCAN,
      ENG_UNTIMED,
      ENG_FINISH
   } eng_state_type;

endpackage

// ----- hw/rtl/timetable_link_cost.sv -----
// top level of the timetable link cost block: registers, output register
// depends on ttlc_pkg, ttlc_mission_mem and ttlc_engine
`timescale 1ns / 1ps

// Cost unit for one link of a transit graph. Each request word loads a
// mission, clears the table, or asks for the untimed or the timed cost;
// each gives exactly one response word. Requests are taken one at a time:
// loads, clears, free-link untimed queries and queries on an undefined link
// go straight to the finish state, an untimed query on a scheduled link
// first reads slot 0, and a timed query sets its starting cost, then scans
// the stored missions, one mission a cycle from the table's read port
// through one shared cost and compare unit. A finished response sits in an
// output register, so the next request is taken while it waits. Registers
// must be written only while the block is idle, not enforced by the block.

module timetable_link_cost
   import ttlc_pkg::*;
#(
   parameter int MAX_MISSIONS = MAX_MISSIONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_MISSIONS > 1) ? $clog2(MAX_MISSIONS) : 1;
   localparam int CNT_W = $clog2(MAX_MISSIONS + 1);

   cfg_type     cfg_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        out_free;
   logic        res_valid;
   rsp_type     res_data;
   logic        mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [IDX_W-1:0] mem_rd_addr;
   mission_type mem_wr_data;
   mission_type mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.free_cost_value <= '0;
         cfg_ff.has_free_link   <= 1'b0;
         cfg_ff.period_length   <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FREE_COST: cfg_ff.free_cost_value <= csr_wdata[FREE_W-1:0];
            CSR_HAS_FREE:  cfg_ff.has_free_link   <= csr_wdata[0];
            CSR_PERIOD:    cfg_ff.period_length   <= csr_wdata[PERIOD_W-1:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ttlc_mission_mem #(
      .DEPTH (MAX_MISSIONS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ttlc_engine #(
      .MAX_MISSIONS (MAX_MISSIONS),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .out_free    (out_free),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

// ----- hw/rtl/ttlc_mission_mem.sv -----
// mission table: one write port, one read port with registered read data
// depends on ttlc_pkg for the mission entry type
`timescale 1ns / 1ps

module ttlc_mission_mem
   import ttlc_pkg::*;
#(
   parameter int DEPTH = MAX_MISSIONS_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  mission_type       wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output mission_type       rd_data
);

   mission_type mem [DEPTH];
   mission_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ttlc_cost_alu.sv -----
// shared cost unit: cost of one mission at the query time and the compare
// against the best cost so far; depends on ttlc_pkg
`timescale 1ns / 1ps

module ttlc_cost_alu
   import ttlc_pkg::*;
(
   input  mission_type               mission,
   input  logic [TIME_BITS-1:0]      query_time,
   input  logic [PERIOD_W-1:0]       period_length,
   input  logic signed [COST_W-1:0]  best_cost,
   output logic signed [COST_W-1:0]  mission_cost,
   output logic                      take
);

   logic                     wraps;
   logic signed [COST_W-1:0] arr_s;
   logic signed [COST_W-1:0] qry_s;
   logic signed [COST_W-1:0] pen_s;

   // a mission that left before the query time is caught next period
   always_comb begin
      wraps = mission.depart < query_time;
      arr_s = $signed({{(COST_W-TIME_BITS){1'b0}}, mission.arrive});
      qry_s = $signed({{(COST_W-TIME_BITS){1'b0}}, query_time});
      pen_s = wraps ? $signed({{(COST_W-PERIOD_W){1'b0}}, period_length})
                    : '0;
      mission_cost = arr_s - qry_s + pen_s;
      // less or equal so a later slot wins a tie
      take = mission_cost <= best_cost;
   end

endmodule

// ----- hw/rtl/ttlc_engine.sv -----
// sequencer of the link cost block: loads, clears, untimed queries and
// the scan through the shared cost unit; depends on ttlc_pkg and ttlc_cost_alu
`timescale 1ns / 1ps

module ttlc_engine
   import ttlc_pkg::*;
#(
   parameter int MAX_MISSIONS = MAX_MISSIONS_DEF,
   parameter int IDX_W = (MAX_MISSIONS > 1) ? $clog2(MAX_MISSIONS) : 1,
   parameter int CNT_W = $clog2(MAX_MISSIONS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   input  req_type           req_data,
   output logic              req_stall,
   output logic              res_valid,
   output rsp_type           res_data,
   input  logic              out_free,
   output logic              mem_wr_en,
   output logic [IDX_W-1:0]  mem_wr_addr,
   output mission_type       mem_wr_data,
   output logic [IDX_W-1:0]  mem_rd_addr,
   input  mission_type       mem_rd_data
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MISSIONS);

   eng_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [TIME_BITS-1:0]     qtime_ff, qtime_in;
   logic signed [COST_W-1:0] best_ff, best_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   mission_type              pick_ff, pick_in;
   rsp_type                  res_ff, res_in;

   logic                     accept;
   logic signed [COST_W-1:0] alu_cost;
   logic                     alu_take;
   logic [COST_W-1:0]        start_cost;
   logic [CNT_W-1:0]         idx_next_cnt;
   logic                     last_slot;
   logic [IDX_W+SEL_INDEX_W-1:0] slot_wide;
   logic [TIME_BITS-1:0]     span;

   ttlc_cost_alu u_alu (
      .mission       (mem_rd_data),
      .query_time    (qtime_ff),
      .period_length (cfg.period_length),
      .best_cost     (best_ff),
      .mission_cost  (alu_cost),
      .take          (alu_take)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ENG_IDLE;
   assign res_valid = state_ff == ENG_FINISH;
   assign res_data  = res_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      qtime_ff <= qtime_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
      pick_ff  <= pick_in;
      res_ff   <= res_in;
   end

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      qtime_in    = qtime_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      pick_in     = pick_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[IDX_W-1:0];
      mem_wr_data = '{depart: req_data.depart_at, arrive: req_data.arrive_at};

      // 100 periods as 64 + 32 + 4
      start_cost = ({{(COST_W-PERIOD_W){1'b0}}, cfg.period_length} << 6)
                 + ({{(COST_W-PERIOD_W){1'b0}}, cfg.period_length} << 5)
                 + ({{(COST_W-PERIOD_W){1'b0}}, cfg.period_length} << 2);
      idx_next_cnt = CNT_W'(idx_ff) + CNT_W'(1);
      last_slot    = idx_next_cnt >= count_ff;
      span         = mem_rd_data.arrive - mem_rd_data.depart;
      slot_wide    = '0;

      unique case (state_ff)
         ENG_IDLE: begin
            if (accept) begin
               res_in = '0;
               res_in.status = ST_OK;
               unique case (req_data.kind) inside
                  KIND_LOAD: begin
                     state_in = ENG_FINISH;
                     if (count_ff >= MAX_CNT) begin
                        res_in.status = ST_FULL;
                     end else if (req_data.arrive_at < req_data.depart_at) begin
                        res_in.status = ST_ORDER;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_CLEAR: begin
                     state_in = ENG_FINISH;
                     count_in = '0;
                  end
                  KIND_UNTIMED, KIND_TIMED: begin
                     idx_in   = '0;
                     qtime_in = req_data.query_time;
                     if (!cfg.has_free_link && count_ff == '0) begin
                        res_in.status = ST_NO_LINK;
                        state_in      = ENG_FINISH;
                     end else if (req_data.kind == KIND_UNTIMED) begin
                        if (cfg.has_free_link) begin
                           res_in.link_cost = $signed({1'b0, cfg.free_cost_value});
                           state_in = ENG_FINISH;
                        end else begin
                           state_in = ENG_UNTIMED;
                        end
                     end else begin
                        state_in = ENG_SETUP;
                     end
                  end
                  default: state_in = ENG_IDLE;
               endcase
            end
         end

         // slot 0 read data is ready here
         ENG_UNTIMED: begin
            res_in.link_cost =
               $signed({{(LINK_COST_W-TIME_BITS){1'b0}}, span});
            res_in.selected_valid   = 1'b1;
            res_in.selected_index   = '0;
            res_in.chosen_departure = mem_rd_data.depart;
            res_in.chosen_arrival   = mem_rd_data.arrive;
            res_in.status           = ST_OK;
            state_in                = ENG_FINISH;
         end

         // starting cost; an empty table with a free link ends here
         ENG_SETUP: begin
            best_in  = cfg.has_free_link
                     ? $signed({{(COST_W-FREE_W){1'b0}}, cfg.free_cost_value})
                     : $signed(start_cost);
            found_in = 1'b0;
            slot_in  = '0;
            if (count_ff == '0) begin
               res_in.link_cost = best_in[LINK_COST_W-1:0];
               state_in = ENG_FINISH;
            end else begin
               state_in = ENG_SCAN;
            end
         end

         // one mission per cycle through the cost unit
         ENG_SCAN: begin
            if (alu_take) begin
               best_in  = alu_cost;
               found_in = 1'b1;
               slot_in  = idx_ff;
               pick_in  = mem_rd_data;
            end
            if (last_slot) begin
               slot_wide = {{SEL_INDEX_W{1'b0}}, slot_in};
               res_in.link_cost      = best_in[LINK_COST_W-1:0];
               res_in.selected_valid = found_in;
               res_in.selected_index = found_in ? slot_wide[SEL_INDEX_W-1:0] : '0;
               res_in.chosen_departure = found_in ? pick_in.depart : '0;
               res_in.chosen_arrival   = found_in ? pick_in.arrive : '0;
               res_in.status           = ST_OK;
               state_in = ENG_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         // hand the word to the output register
         ENG_FINISH: begin
            if (out_free) begin
               state_in = ENG_IDLE;
            end
         end

         default: state_in = ENG_IDLE;
      endcase
   end

   assign mem_rd_addr = idx_in;

   // table never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("mission count above table depth");

   // scan index stays inside the filled part of the table
   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_SCAN |-> CNT_W'(idx_ff) < count_ff)
      else $error("scan index past last mission");

   // a clear empties the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_CLEAR |=> count_ff == '0)
      else $error("clear left missions in table");

   // a chosen mission only comes with an ok status
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ff.selected_valid |-> res_ff.status == ST_OK)
      else $error("mission chosen with error status");

endmodule

// ----- tb/sv/ttlc_cost_checker.sv -----
// checker for the timetable link cost block: predicts every response word
// from the request and register traffic and compares it; uses ttlc_pkg
`timescale 1ns / 1ps

module ttlc_cost_checker
   import ttlc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending
);

   localparam int     TABLE_DEPTH     = MAX_MISSIONS_DEF;
   localparam longint NO_LINK_PERIODS = 100;
   localparam int     REPORT_LIMIT    = 10;

   // shadow registers
   logic [FREE_W-1:0]    free_val;
   logic                 has_free;
   logic [PERIOD_W-1:0]  period;

   // shadow mission table
   logic [TIME_BITS-1:0] depart_table [TABLE_DEPTH];
   logic [TIME_BITS-1:0] arrive_table [TABLE_DEPTH];
   int                   loaded;

   rsp_type              owed_words [$];
   rsp_type              want;
   logic                 bad;

   // cost of one request word, updates the shadow table
   function automatic rsp_type price_word(req_type w);
      rsp_type r;
      longint  best;
      longint  c;
      longint  t;
      int      slot;
      logic    found;
      int      i;
      r = '0;
      case (w.kind) inside
         KIND_LOAD: begin
            // full check comes before the order check
            if (loaded >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else if (w.arrive_at < w.depart_at) begin
               r.status = ST_ORDER;
            end else begin
               depart_table[loaded] = w.depart_at;
               arrive_table[loaded] = w.arrive_at;
               loaded++;
            end
         end
         KIND_CLEAR: begin
            loaded = 0;
         end
         KIND_UNTIMED, KIND_TIMED: begin
            if (!has_free && loaded == 0) begin
               r.status = ST_NO_LINK;
            end else if (w.kind == KIND_UNTIMED) begin
               if (has_free) begin
                  r.link_cost = LINK_COST_W'(longint'(free_val));
               end else begin
                  r.link_cost = LINK_COST_W'(longint'(arrive_table[0]) -
                                             longint'(depart_table[0]));
                  r.selected_valid   = 1'b1;
                  r.chosen_departure = depart_table[0];
                  r.chosen_arrival   = arrive_table[0];
               end
            end else begin
               // scan from slot 0 up, later slot wins a tie
               best  = has_free ? longint'(free_val)
                                : NO_LINK_PERIODS * longint'(period);
               t     = longint'(w.query_time);
               found = 1'b0;
               slot  = 0;
               for (i = 0; i < loaded; i++) begin
                  c = longint'(arrive_table[i]) - t;
                  if (longint'(depart_table[i]) < t) c += longint'(period);
                  if (c <= best) begin
                     best  = c;
                     slot  = i;
                     found = 1'b1;
                  end
               end
               r.link_cost = LINK_COST_W'(best);
               if (found) begin
                  r.selected_valid   = 1'b1;
                  r.selected_index   = SEL_INDEX_W'(slot);
                  r.chosen_departure = depart_table[slot];
                  r.chosen_arrival   = arrive_table[slot];
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         free_val  = '0;
         has_free  = 1'b0;
         period    = PERIOD_RESET;
         loaded    = 0;
         owed_words.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_FREE_COST: free_val  = csr_wdata[FREE_W-1:0];
               CSR_HAS_FREE:  has_free  = csr_wdata[0];
               CSR_PERIOD:    period    = csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         // response side, compared before this edge's request is priced
         if (rsp_valid && !rsp_stall) begin
            if (owed_words.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: response word with none owed: cost %0d status %0d",
                           $time, rsp_data.link_cost, rsp_data.status);
               end
            end else begin
               want = owed_words.pop_front();
               bad  = (rsp_data.link_cost        != want.link_cost)        ||
                      (rsp_data.selected_valid   != want.selected_valid)   ||
                      (rsp_data.selected_index   != want.selected_index)   ||
                      (rsp_data.chosen_departure != want.chosen_departure) ||
                      (rsp_data.chosen_arrival   != want.chosen_arrival)   ||
                      (rsp_data.status           != want.status);
               if (bad) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: want cost %0d sel %0b/%0d dep %h arr %h st %0d",
                              $time, want.link_cost, want.selected_valid,
                              want.selected_index, want.chosen_departure,
                              want.chosen_arrival, want.status);
                     $display("%0t:  got cost %0d sel %0b/%0d dep %h arr %h st %0d",
                              $time, rsp_data.link_cost, rsp_data.selected_valid,
                              rsp_data.selected_index, rsp_data.chosen_departure,
                              rsp_data.chosen_arrival, rsp_data.status);
                  end
               end
            end
         end
         // request side
         if (req_valid && !req_stall) begin
            owed_words.insert(owed_words.size(), price_word(req_data));
         end
      end
      pending = owed_words.size();
   end

endmodule

// ----- tb/sv/timetable_link_cost_test.sv -----
// top of the timetable link cost testbench: clock, reset, stimulus, verdict
// depends on ttlc_pkg, timetable_link_cost and ttlc_cost_checker
`timescale 1ns / 1ps

module timetable_link_cost_test;
   import ttlc_pkg::*;

   localparam int                   ITEM_TARGET   = 1100;
   localparam int                   CYCLE_LIMIT   = 600000;
   localparam int                   IDLE_MAX      = 16;
   localparam int                   SETTLE_CYCLES = 30;
   localparam logic [TIME_BITS-1:0] TIME_MAX      = '1;
   localparam logic [FREE_W-1:0]    FREE_MAX      = '1;
   localparam logic [PERIOD_W-1:0]  PERIOD_MAX    = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     error_count;
   int                     pending;
   int                     cycles     = 0;
   int                     words_sent = 0;
   int                     send_calm  = 0;
   int                     recv_calm  = 0;
   mission_type            recent [$];

   timetable_link_cost dut (.*);

   ttlc_cost_checker cost_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timetable_link_cost_test: done, errors");
         $finish;
      end
   end

   function automatic req_type make_word(logic [1:0] kind, logic [TIME_BITS-1:0] dep,
                                         logic [TIME_BITS-1:0] arr,
                                         logic [TIME_BITS-1:0] t);
      return '{kind: kind, depart_at: dep, arrive_at: arr, query_time: t};
   endfunction

   // one request word: random gap, then hold until taken
   task automatic send_word(input req_type w);
      int          gap;
      mission_type entry;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
         gap = $urandom_range(0, IDLE_MAX);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
      // track the table contents for aiming queries and copying missions
      if (w.kind == KIND_CLEAR) begin
         recent.delete();
      end else if (w.kind == KIND_LOAD && w.arrive_at >= w.depart_at &&
                   recent.size() < MAX_MISSIONS_DEF) begin
         entry.depart = w.depart_at;
         entry.arrive = w.arrive_at;
         recent.insert(recent.size(), entry);
      end
   endtask

   // hold off until every owed response word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // write all three registers with the block idle
   task automatic configure(input logic [FREE_W-1:0] free, input logic has,
                            input logic [PERIOD_W-1:0] per);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_FREE_COST;
      csr_wdata <= CSR_DATA_W'(free);
      @(posedge clock);
      csr_index <= CSR_HAS_FREE;
      csr_wdata <= CSR_DATA_W'(has);
      @(posedge clock);
      csr_index <= CSR_PERIOD;
      csr_wdata <= CSR_DATA_W'(per);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // response side stalls
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (recv_calm > 0) begin
            recv_calm--;
            gap = 0;
         end else begin
            if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 60);
            gap = $urandom_range(0, IDLE_MAX);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // stimulus and verdict
   initial begin
      int                   phase;
      int                   n_loads;
      int                   n_queries;
      int                   base;
      int                   stop;
      int                   pick;
      logic [TIME_BITS-1:0] dep;
      logic [TIME_BITS-1:0] arr;
      logic [TIME_BITS-1:0] t;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, no free link
      send_word(make_word(KIND_UNTIMED, 0, 0, 0));
      send_word(make_word(KIND_TIMED, 0, 0, TIME_MAX));
      send_word(make_word(KIND_LOAD, TIME_MAX, 0, 0));
      send_word(make_word(KIND_LOAD, 0, 0, 0));
      send_word(make_word(KIND_LOAD, 0, TIME_MAX, 0));
      send_word(make_word(KIND_UNTIMED, 0, 0, 0));
      send_word(make_word(KIND_TIMED, 0, 0, 0));
      send_word(make_word(KIND_TIMED, 0, 0, TIME_MAX));
      send_word(make_word(KIND_LOAD, TIME_MAX, TIME_MAX, 0));
      send_word(make_word(KIND_TIMED, 0, 0, TIME_MAX));
      send_word(make_word(KIND_CLEAR, 0, 0, 0));
      // equal missions, the later slot wins
      send_word(make_word(KIND_LOAD, 10, 20, 0));
      send_word(make_word(KIND_LOAD, 10, 20, 0));
      send_word(make_word(KIND_TIMED, 0, 0, 5));
      send_word(make_word(KIND_CLEAR, 0, 0, 0));

      // directed: free link on an empty table, then a mission tying the free cost
      configure(10, 1'b1, 1);
      send_word(make_word(KIND_UNTIMED, 0, 0, 0));
      send_word(make_word(KIND_TIMED, 0, 0, 7));
      send_word(make_word(KIND_LOAD, 5, 15, 0));
      send_word(make_word(KIND_TIMED, 0, 0, 5));
      send_word(make_word(KIND_UNTIMED, 0, 0, 0));
      send_word(make_word(KIND_CLEAR, 0, 0, 0));
      configure(FREE_MAX, 1'b1, PERIOD_MAX);
      send_word(make_word(KIND_TIMED, 0, 0, 0));

      // random phases, each under its own register setting
      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         case (phase % 6)
            0: configure(0, 1'b0, 1);
            1: configure(FREE_MAX, 1'b0, PERIOD_MAX);
            2: configure(FREE_W'($urandom), 1'b1, PERIOD_W'($urandom_range(1, PERIOD_MAX)));
            3: configure(FREE_W'($urandom_range(0, 4000)), 1'b1,
                         PERIOD_W'($urandom_range(1, 50)));
            4: configure(FREE_W'($urandom), 1'(($urandom_range(0, 1))), PERIOD_RESET);
            default: configure(FREE_W'($urandom), 1'b0,
                               PERIOD_W'($urandom_range(1, PERIOD_MAX)));
         endcase
         phase++;
         repeat (6) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any kind, any field values
               repeat (8) begin
                  send_word(make_word(2'($urandom_range(0, 3)), TIME_BITS'($urandom),
                                      TIME_BITS'($urandom), TIME_BITS'($urandom)));
               end
            end else begin
               // clear most times, fill with missions mostly in one window, then query
               if ($urandom_range(0, 3) != 0) send_word(make_word(KIND_CLEAR, 0, 0, 0));
               base    = $urandom_range(0, TIME_MAX);
               n_loads = $urandom_range(0, 18);
               repeat (n_loads) begin
                  if ($urandom_range(0, 9) == 0) begin
                     dep = TIME_BITS'($urandom_range(1, TIME_MAX));
                     arr = TIME_BITS'($urandom_range(0, dep - 1));
                  end else if ($urandom_range(0, 7) == 0 && recent.size() > 0) begin
                     pick = $urandom_range(0, recent.size() - 1);
                     dep  = recent[pick].depart;
                     arr  = recent[pick].arrive;
                  end else begin
                     dep  = TIME_BITS'(base + $urandom_range(0, 200000));
                     stop = int'(dep) + $urandom_range(0, 5000);
                     arr  = (stop > int'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(stop);
                  end
                  send_word(make_word(KIND_LOAD, dep, arr, TIME_BITS'($urandom)));
               end
               n_queries = $urandom_range(1, 8);
               repeat (n_queries) begin
                  if (recent.size() > 0 && $urandom_range(0, 2) != 0) begin
                     pick = $urandom_range(0, recent.size() - 1);
                     t    = TIME_BITS'(int'(recent[pick].depart) + $urandom_range(0, 6) - 3);
                  end else begin
                     t = TIME_BITS'($urandom);
                  end
                  send_word(make_word(($urandom_range(0, 3) == 0) ? KIND_UNTIMED : KIND_TIMED,
                                      TIME_BITS'($urandom), TIME_BITS'($urandom), t));
               end
            end
            // now and then let the block run dry mid-phase
            if ($urandom_range(0, 19) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("timetable_link_cost_test: done, clean");
      end else begin
         $display("timetable_link_cost_test: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/ttlc_pkg.sv
hw/rtl/ttlc_mission_mem.sv
hw/rtl/ttlc_cost_alu.sv
hw/rtl/ttlc_engine.sv
hw/rtl/timetable_link_cost.sv
tb/sv/ttlc_cost_checker.sv
tb/sv/timetable_link_cost_test.sv
